// ===== src/ctf_pkg.sv =====
`default_nettype none

package ctf_pkg;

  localparam int CORDIC_STEPS        = 16;
  localparam int ANGLE_FRACTION_BITS = 15;

  localparam int CORDIC_ITERS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int IDX_W        = 5;
  localparam int CNT_W        = 6;

  localparam int XY_W  = 34;
  localparam int Z_W   = 35;
  localparam int MAG_W = 34;

  localparam logic signed [Z_W-1:0] PI_Q30 = 35'sd3373259426;

  localparam int SQ_W     = 56;
  localparam int SQ_STEPS = 28;
  localparam int ROOT_W   = 28;

  localparam int DEG_DIVISOR = 6283;
  localparam int DEG_SCALE   = 360000;
  localparam int DEG_SH      = 30 - ANGLE_FRACTION_BITS;
  localparam int N_W         = 53;
  localparam int T_W         = N_W - DEG_SH;
  localparam int Q_W         = T_W - 12;
  localparam int TILT_W      = Q_W + 1;
  localparam logic [N_W-1:0] HALF_DEN =
    N_W'(longint'(DEG_DIVISOR) << (29 - ANGLE_FRACTION_BITS));

  localparam int G_SH     = 28 - ANGLE_FRACTION_BITS;
  localparam int PRED_W   = (((24 + G_SH) > 40) ? (24 + G_SH) : 40) + 2;
  localparam int TERM_A_W = 17 + TILT_W + G_SH;
  localparam int TERM_B_W = 16 + PRED_W;
  localparam int ACC_W    = ((TERM_A_W > TERM_B_W) ? TERM_A_W : TERM_B_W) + 2;
  localparam int BLEND_SH = G_SH + 16;

  localparam int MA_W0 = (PRED_W > (T_W + 1)) ? PRED_W : (T_W + 1);
  localparam int MA_W1 = (MA_W0 > (MAG_W + 1)) ? MA_W0 : (MAG_W + 1);
  localparam int MA_W  = (MA_W1 > 25) ? MA_W1 : 25;
  localparam int MB_W  = ((ANGLE_FRACTION_BITS + 4) > 20) ? (ANGLE_FRACTION_BITS + 4) : 20;
  localparam int P_W   = MA_W + MB_W;

  // Division by the degree divisor is a multiplication by a rounded-up
  // reciprocal, split in two halves that fit the shared multiplier.
  localparam int     DEG_K     = 34 + ANGLE_FRACTION_BITS;
  localparam int     DEG_LO_W  = 19;
  localparam int     DEG_QSH   = DEG_K - DEG_LO_W;
  localparam longint DEG_RECIP =
    ((longint'(1) << DEG_K) + longint'(DEG_DIVISOR) - 1) / longint'(DEG_DIVISOR);
  localparam logic signed [MB_W-1:0] DEG_RECIP_LO =
    MB_W'(DEG_RECIP & ((longint'(1) << DEG_LO_W) - 1));
  localparam logic signed [MB_W-1:0] DEG_RECIP_HI = MB_W'(DEG_RECIP >> DEG_LO_W);

  localparam logic CFG_BLEND_WEIGHT = 1'b0;
  localparam logic CFG_STEP_SIZE    = 1'b1;

  typedef struct packed {
    logic             load;
    logic             step;
    logic [IDX_W-1:0] idx;
  } cordic_ctrl_t;

  function automatic logic [Z_W-1:0] atan_q30(input logic [IDX_W-1:0] idx);
    logic [Z_W-1:0] v;
    case (idx)
      5'd0:    v = 35'h03243F6A8;
      5'd1:    v = 35'h01DAC6705;
      5'd2:    v = 35'h00FADBAFC;
      5'd3:    v = 35'h007F56EA6;
      5'd4:    v = 35'h003FEAB76;
      5'd5:    v = 35'h001FFD55B;
      5'd6:    v = 35'h000FFFAAA;
      5'd7:    v = 35'h0007FFF55;
      5'd8:    v = 35'h0003FFFEA;
      5'd9:    v = 35'h0001FFFFD;
      5'd10:   v = 35'h0000FFFFF;
      5'd11:   v = 35'h00007FFFF;
      5'd12:   v = 35'h00003FFFF;
      5'd13:   v = 35'h00001FFFF;
      5'd14:   v = 35'h00000FFFF;
      5'd15:   v = 35'h000007FFF;
      5'd16:   v = 35'h000003FFF;
      5'd17:   v = 35'h000001FFF;
      5'd18:   v = 35'h000000FFF;
      5'd19:   v = 35'h0000007FF;
      5'd20:   v = 35'h0000003FF;
      5'd21:   v = 35'h0000001FF;
      5'd22:   v = 35'h0000000FF;
      5'd23:   v = 35'h00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== src/ctf_cordic.sv =====
`default_nettype none

module ctf_cordic
  import ctf_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire cordic_ctrl_t            ctrl_i,
  input  wire logic signed [XY_W-1:0]  x_i,
  input  wire logic signed [XY_W-1:0]  y_i,
  output logic             [MAG_W-1:0] z_mag_o,
  output logic                         z_neg_o
);

  logic signed [XY_W-1:0] x_q;
  logic signed [XY_W-1:0] y_q;
  logic signed [Z_W-1:0]  z_q;
  logic                   skip_q;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [Z_W-1:0]  at;

  assign xs = x_q >>> ctrl_i.idx;
  assign ys = y_q >>> ctrl_i.idx;
  assign at = $signed(atan_q30(ctrl_i.idx));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      if (x_i == '0 && y_i == '0) begin
        x_q    <= '0;
        y_q    <= '0;
        z_q    <= '0;
        skip_q <= 1'b1;
      end else if (x_i < 0) begin
        x_q    <= -x_i;
        y_q    <= -y_i;
        z_q    <= (y_i >= 0) ? PI_Q30 : -PI_Q30;
        skip_q <= 1'b0;
      end else begin
        x_q    <= x_i;
        y_q    <= y_i;
        z_q    <= '0;
        skip_q <= 1'b0;
      end
    end else if (ctrl_i.step && !skip_q) begin
      if (y_q >= 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end
    end
  end

  assign z_neg_o = z_q < 0;
  assign z_mag_o = z_neg_o ? MAG_W'(-z_q) : MAG_W'(z_q);

endmodule

`default_nettype wire

// ===== src/complementary_tilt_filter.sv =====
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    accel_x/y/z, rate_roll, rate_pitch
// out      output     out_valid_o / out_stall_i  roll_angle, pitch_angle
// cfg      input      cfg_we_i                   cfg_idx_i, cfg_data_i
// A request is taken only while the block is idle, so the next request is taken only
// after the result of the last one has been loaded into the output register.
// Each request passes through the bit-serial square root and the shared CORDIC stage,
// which runs once per axis, followed by a reciprocal multiplication and the blend.
// Reset clears both estimates and loads the default weight and step.
// A finished result waits in the output register while a new request is taken.

`default_nettype none

module complementary_tilt_filter
  import ctf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] accel_x_i,
  input  wire logic signed [15:0] accel_y_i,
  input  wire logic signed [15:0] accel_z_i,
  input  wire logic signed [15:0] rate_roll_i,
  input  wire logic signed [15:0] rate_pitch_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [23:0]      roll_angle_o,
  output logic signed [23:0]      pitch_angle_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [23:0]        cfg_data_i
);

  typedef enum logic [16:0] {
    S_IDLE  = 17'b00000000000000001,
    S_SQY   = 17'b00000000000000010,
    S_SQZ   = 17'b00000000000000100,
    S_SQADD = 17'b00000000000001000,
    S_SQRT  = 17'b00000000000010000,
    S_CINIT = 17'b00000000000100000,
    S_CORD  = 17'b00000000001000000,
    S_DMUL  = 17'b00000000010000000,
    S_DINIT = 17'b00000000100000000,
    S_DLO   = 17'b00000001000000000,
    S_DHI   = 17'b00000010000000000,
    S_DQ    = 17'b00000100000000000,
    S_B1    = 17'b00001000000000000,
    S_B2    = 17'b00010000000000000,
    S_B3    = 17'b00100000000000000,
    S_B4    = 17'b01000000000000000,
    S_OUT   = 17'b10000000000000000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0] cnt_q;
  logic             axis_q;
  logic [15:0]      w_q;
  logic [23:0]      h_q;
  logic signed [23:0] roll_est_q;
  logic signed [23:0] pitch_est_q;
  logic               out_valid_q;
  logic signed [23:0] roll_out_q;
  logic signed [23:0] pitch_out_q;

  logic signed [15:0] ax_q, ay_q, az_q, gr_q, gp_q;
  logic signed [P_W-1:0]    prod_q;
  logic [31:0]              sumsq_q;
  logic [SQ_W-1:0]          sq_n_q, sq_res_q, sq_bit_q;
  logic [T_W-1:0]           deg_t_q;
  logic [P_W-1:0]           dlo_q;
  logic [Q_W-1:0]           tq_q;
  logic signed [PRED_W-1:0] pred_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic in_acc, out_acc, out_load;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [P_W-1:0]   prod_d;
  logic [SQ_W-1:0]         sq_try;
  logic [N_W-1:0]          deg_n;
  logic [T_W-1:0]          deg_t;
  logic [P_W:0]            deg_sum;
  logic [Q_W-1:0]          deg_q;
  logic signed [TILT_W-1:0] tilt_mag, tilt;
  logic signed [23:0]      est_sel;
  logic signed [15:0]      rate_sel;
  logic [16:0]             w_comp;
  logic signed [ACC_W-1:0] blend_sum, blend_r;
  logic signed [23:0]      blend_sat;
  logic signed [XY_W-1:0]  cx, cy;
  cordic_ctrl_t            cctrl;
  logic [MAG_W-1:0]        z_mag;
  logic                    z_neg;

  localparam logic signed [ACC_W-1:0] BLEND_ROUND =
    ACC_W'(longint'(1) << (G_SH + 15));
  localparam logic signed [ACC_W-1:0] EST_MAX = ACC_W'(8388607);
  localparam logic signed [ACC_W-1:0] EST_MIN = -ACC_W'(8388608);

  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (state_q != S_IDLE);

  assign est_sel  = axis_q ? pitch_est_q : roll_est_q;
  assign rate_sel = axis_q ? gp_q : gr_q;
  assign w_comp   = 17'd65536 - {1'b0, w_q};
  assign tilt_mag = $signed({1'b0, tq_q});
  assign tilt     = z_neg ? -tilt_mag : tilt_mag;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_IDLE:  mul_a = '0;
      S_SQY:   begin mul_a = MA_W'(ay_q); mul_b = MB_W'(ay_q); end
      S_SQZ:   begin mul_a = MA_W'(az_q); mul_b = MB_W'(az_q); end
      S_DMUL:  begin mul_a = MA_W'(z_mag); mul_b = MB_W'(DEG_SCALE); end
      S_DLO:   begin mul_a = MA_W'(deg_t_q); mul_b = DEG_RECIP_LO; end
      S_DHI:   begin mul_a = MA_W'(deg_t_q); mul_b = DEG_RECIP_HI; end
      S_B1:    begin mul_a = MA_W'(h_q); mul_b = MB_W'(rate_sel); end
      S_B2:    begin mul_a = MA_W'(tilt); mul_b = MB_W'(w_comp); end
      S_B3:    begin mul_a = MA_W'(pred_q); mul_b = MB_W'(w_q); end
      default: mul_a = '0;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  assign sq_try  = sq_res_q + sq_bit_q;
  assign deg_n   = prod_q[N_W-1:0] + HALF_DEN;
  assign deg_t   = T_W'(deg_n >> DEG_SH);
  assign deg_sum = {1'b0, prod_q} + {1'b0, (dlo_q >> DEG_LO_W)};
  assign deg_q   = Q_W'(deg_sum >> DEG_QSH);

  assign blend_sum = acc_q + ACC_W'(prod_q);
  assign blend_r   = (blend_sum + BLEND_ROUND) >>> BLEND_SH;
  always_comb begin
    priority if (blend_r > EST_MAX) begin
      blend_sat = 24'sh7FFFFF;
    end else if (blend_r < EST_MIN) begin
      blend_sat = -24'sh800000;
    end else begin
      blend_sat = 24'(blend_r);
    end
  end

  assign cx = axis_q ? XY_W'(sq_res_q[ROOT_W-1:0]) : (XY_W'(az_q) <<< 12);
  assign cy = axis_q ? -(XY_W'(ax_q) <<< 12) : (XY_W'(ay_q) <<< 12);
  assign cctrl.load = (state_q == S_CINIT);
  assign cctrl.step = (state_q == S_CORD);
  assign cctrl.idx  = cnt_q[IDX_W-1:0];

  ctf_cordic u_cordic (
    .clk_i   (clk_i),
    .ctrl_i  (cctrl),
    .x_i     (cx),
    .y_i     (cy),
    .z_mag_o (z_mag),
    .z_neg_o (z_neg)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_SQY;
      S_SQY:   state_d = S_SQZ;
      S_SQZ:   state_d = S_SQADD;
      S_SQADD: state_d = S_SQRT;
      S_SQRT:  if (cnt_q == CNT_W'(SQ_STEPS - 1)) state_d = S_CINIT;
      S_CINIT: state_d = S_CORD;
      S_CORD:  if (cnt_q == CNT_W'(CORDIC_ITERS - 1)) state_d = S_DMUL;
      S_DMUL:  state_d = S_DINIT;
      S_DINIT: state_d = S_DLO;
      S_DLO:   state_d = S_DHI;
      S_DHI:   state_d = S_DQ;
      S_DQ:    state_d = S_B1;
      S_B1:    state_d = S_B2;
      S_B2:    state_d = S_B3;
      S_B3:    state_d = S_B4;
      S_B4:    state_d = axis_q ? S_OUT : S_CINIT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      axis_q      <= 1'b0;
      w_q         <= 16'd64225;
      h_q         <= 24'd16777;
      roll_est_q  <= '0;
      pitch_est_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BLEND_WEIGHT: w_q <= cfg_data_i[15:0];
          CFG_STEP_SIZE:    h_q <= cfg_data_i;
          default:          w_q <= w_q;
        endcase
      end
      if (state_q != state_d || state_q == S_IDLE) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (state_q == S_IDLE) begin
        axis_q <= 1'b0;
      end else if (state_q == S_B4) begin
        axis_q <= 1'b1;
        if (axis_q) begin
          pitch_est_q <= blend_sat;
        end else begin
          roll_est_q <= blend_sat;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (in_acc) begin
      ax_q <= accel_x_i;
      ay_q <= accel_y_i;
      az_q <= accel_z_i;
      gr_q <= rate_roll_i;
      gp_q <= rate_pitch_i;
    end
    if (state_q == S_SQZ) begin
      sumsq_q <= prod_q[31:0];
    end
    if (state_q == S_SQADD) begin
      sq_n_q   <= {sumsq_q + prod_q[31:0], 24'b0};
      sq_res_q <= '0;
      sq_bit_q <= SQ_W'(1) << (2 * (SQ_STEPS - 1));
    end else if (state_q == S_SQRT) begin
      if (sq_n_q >= sq_try) begin
        sq_n_q   <= sq_n_q - sq_try;
        sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
      end else begin
        sq_res_q <= sq_res_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
    if (state_q == S_DINIT) begin
      deg_t_q <= deg_t;
    end
    if (state_q == S_DHI) begin
      dlo_q <= prod_q;
    end
    if (state_q == S_DQ) begin
      tq_q <= deg_q;
    end
    if (state_q == S_B2) begin
      pred_q <= (PRED_W'(est_sel) <<< G_SH) + PRED_W'(prod_q);
    end
    if (state_q == S_B3) begin
      acc_q <= ACC_W'(prod_q) <<< G_SH;
    end
    if (out_load) begin
      roll_out_q  <= roll_est_q;
      pitch_out_q <= pitch_est_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign roll_angle_o  = roll_out_q;
  assign pitch_angle_o = pitch_out_q;

endmodule

`default_nettype wire

// ===== src/ctf_checker.sv =====
`default_nettype none

module ctf_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic signed [15:0] accel_x_i,
  input wire logic signed [15:0] accel_y_i,
  input wire logic signed [15:0] accel_z_i,
  input wire logic signed [15:0] rate_roll_i,
  input wire logic signed [15:0] rate_pitch_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [23:0] roll_angle_o,
  input wire logic signed [23:0] pitch_angle_o,
  input wire logic               cfg_we_i,
  input wire logic               cfg_idx_i,
  input wire logic [23:0]        cfg_data_i
);

  // The block is busy right after it takes a request.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a request");

  // A new result never appears in the cycle after a request is taken.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // When a result is posted the block is ready again.
  a_ready_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("block busy when a result is posted");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(roll_angle_o)
      && $stable(pitch_angle_o))
    else $error("stalled result changed");

endmodule

bind complementary_tilt_filter ctf_checker u_ctf_checker (.*);

`default_nettype wire

// ===== bench/complementary_tilt_filter_tb.sv =====
`default_nettype none

module complementary_tilt_filter_tb
  import ctf_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic signed [23:0] roll;
    logic signed [23:0] pitch;
  } angle_pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] accel_x_i = '0;
  logic signed [15:0] accel_y_i = '0;
  logic signed [15:0] accel_z_i = '0;
  logic signed [15:0] rate_roll_i = '0;
  logic signed [15:0] rate_pitch_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [23:0] roll_angle_o;
  logic signed [23:0] pitch_angle_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [23:0] cfg_data_i = '0;

  logic [15:0] weight_q16;
  logic [23:0] step_q24;
  logic signed [23:0] roll_est;
  logic signed [23:0] pitch_est;
  angle_pair_t pending_attitudes[$];
  int errors = 0;
  longint cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;

  complementary_tilt_filter dut (.*);

  always #2 clk_i = ~clk_i;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint res;
    longint bitv;
    res = 0;
    bitv = longint'(1) << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint atan_table(int i);
    longint t[24] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA,
      64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF,
      64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF,
      64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    return t[i];
  endfunction

  function automatic longint atan2_degrees(longint y, longint x);
    longint z;
    longint xs;
    longint ys;
    longint den;
    longint mag;
    longint q;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_table(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_table(i);
      end
    end
    den = 64'sd6283 * (longint'(1) << (30 - ANGLE_FRACTION_BITS));
    mag = (z < 0) ? -z : z;
    q = (mag * 360000 + den / 2) / den;
    return (z < 0) ? -q : q;
  endfunction

  function automatic logic signed [23:0] blend_estimate(longint tilt, longint est,
                                                        longint rate);
    int g;
    longint w;
    longint pred;
    longint acc;
    longint r;
    g = 28 - ANGLE_FRACTION_BITS;
    w = longint'(weight_q16);
    pred = est * (longint'(1) << g) + longint'(step_q24) * rate;
    acc = (65536 - w) * tilt * (longint'(1) << g) + w * pred;
    r = floor_shift(acc + (longint'(1) << (g + 15)), g + 16);
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return 24'(r);
  endfunction

  function automatic angle_pair_t predict_attitude(logic signed [15:0] ax,
                                                   logic signed [15:0] ay,
                                                   logic signed [15:0] az,
                                                   logic signed [15:0] gr,
                                                   logic signed [15:0] gp);
    angle_pair_t a;
    longint mag;
    mag = int_sqrt((longint'(ay) * ay + longint'(az) * az) << 24);
    roll_est = blend_estimate(atan2_degrees(longint'(ay) * 4096, longint'(az) * 4096),
                              roll_est, gr);
    pitch_est = blend_estimate(atan2_degrees(-longint'(ax) * 4096, mag), pitch_est, gp);
    a.roll = roll_est;
    a.pitch = pitch_est;
    return a;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("complementary_tilt_filter_tb: FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    angle_pair_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_attitudes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result roll=%0d pitch=%0d",
                                   roll_angle_o, pitch_angle_o);
      end else begin
        want = pending_attitudes.pop_front();
        if (want.roll !== roll_angle_o || want.pitch !== pitch_angle_o) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected roll=%0d pitch=%0d, got roll=%0d pitch=%0d",
                     want.roll, want.pitch, roll_angle_o, pitch_angle_o);
        end
      end
    end
  end

  task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                             logic signed [15:0] az, logic signed [15:0] gr,
                             logic signed [15:0] gp, bit use_gaps);
    if (use_gaps) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(negedge clk_i);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    in_valid_i <= 1'b1;
    accel_x_i <= ax;
    accel_y_i <= ay;
    accel_z_i <= az;
    rate_roll_i <= gr;
    rate_pitch_i <= gp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_attitudes.push_back(predict_attitude(ax, ay, az, gr, gp));
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_attitudes.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(logic idx, logic [23:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BLEND_WEIGHT) weight_q16 = value[15:0];
    else step_q24 = value;
  endtask

  task automatic test_directed();
    stall_mode = 0;
    send_sample(0, 0, 0, 0, 0, 0);
    send_sample(0, 0, -100, 0, 0, 0);
    send_sample(0, -5, -100, 0, 0, 0);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
    send_sample(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 0);
    send_sample(-16'sh8000, 0, 0, 16'sh7FFF, -16'sh8000, 0);
    send_sample(16'sh7FFF, 0, 0, 0, 0, 0);
    send_sample(0, 16'sh7FFF, 0, 0, 0, 0);
    send_sample(0, -16'sh8000, 16'sh7FFF, 0, 0, 0);
    send_sample(1, 1, 1, 1, -1, 0);
    send_sample(-1, -1, -1, -1, 1, 0);
    send_sample(0, 1, -1, 100, 100, 0);
    wait_idle();
  endtask

  task automatic test_saturation();
    write_register(CFG_BLEND_WEIGHT, 24'hFFFF);
    write_register(CFG_STEP_SIZE, 24'hFFFFFF);
    stall_mode = 1;
    for (int i = 0; i < 12; i++)
      send_sample(0, 0, 1000, 16'sh7FFF, -16'sh8000, 1);
    for (int i = 0; i < 12; i++)
      send_sample(0, 0, 1000, -16'sh8000, 16'sh7FFF, 1);
    wait_idle();
  endtask

  task automatic run_random(int count);
    logic signed [15:0] f[5];
    for (int i = 0; i < count; i++) begin
      foreach (f[k]) begin
        case ($urandom_range(0, 3))
          0: f[k] = 16'($urandom_range(0, 65535));
          1: f[k] = 16'($urandom_range(0, 40)) - 16'sd20;
          2: f[k] = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : -16'sh8000;
          default: f[k] = 16'($urandom_range(0, 4000)) - 16'sd2000;
        endcase
      end
      if ($urandom_range(0, 15) == 0) begin
        f[1] = 0;
        f[2] = 0;
      end
      send_sample(f[0], f[1], f[2], f[3], f[4], 1);
      if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
    end
    wait_idle();
  endtask

  task automatic test_config_sweep();
    logic [15:0] weights[4] = '{16'd0, 16'd64225, 16'd32768, 16'd1};
    logic [23:0] steps[4] = '{24'd0, 24'd16777, 24'd5000000, 24'd1};
    for (int p = 0; p < 4; p++) begin
      write_register(CFG_BLEND_WEIGHT, 24'(weights[p]));
      write_register(CFG_STEP_SIZE, steps[p]);
      stall_mode = p % 3;
      run_random(120);
    end
    write_register(CFG_BLEND_WEIGHT, 24'($urandom_range(0, 65535)));
    write_register(CFG_STEP_SIZE, 24'($urandom_range(0, 24'hFFFFFF)));
    run_random(200);
    write_register(CFG_BLEND_WEIGHT, 24'd64225);
    write_register(CFG_STEP_SIZE, 24'd16777);
    run_random(300);
  endtask

  initial begin
    weight_q16 = 16'd64225;
    step_q24 = 24'd16777;
    roll_est = '0;
    pitch_est = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_saturation();
    test_config_sweep();
    if (errors == 0) begin
      $display("complementary_tilt_filter_tb: PASS");
    end else begin
      $display("complementary_tilt_filter_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/ctf_pkg.sv
src/ctf_cordic.sv
src/complementary_tilt_filter.sv
src/ctf_checker.sv
bench/complementary_tilt_filter_tb.sv
